### hw/rtl/rpwc_pkg.sv
// ----------------------------------------------------------------------------
// rpwc_pkg
// Shared types and constants of the radio-control pulse-width capture block.
// ----------------------------------------------------------------------------
package rpwc_pkg;

	localparam int NUM_CHANNELS_DEF = 5;
	localparam int CH_W             = 3;
	localparam int TIME_W           = 16;
	localparam int VALUE_W          = 12;
	localparam int DB_W             = 11;
	localparam int STATUS_W         = 2;
	localparam int CFG_INDEX_W      = 3;
	localparam int CFG_DATA_W       = 16;

	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [CH_W-1:0] CH_ROLL     = 3'd0;
	localparam logic [CH_W-1:0] CH_PITCH    = 3'd1;
	localparam logic [CH_W-1:0] CH_THROTTLE = 3'd2;
	localparam logic [CH_W-1:0] CH_YAW      = 3'd3;

	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DISCONNECTED  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ROLL_SEEN     = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_THROTTLE_SEEN = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_ROLL_CENTER      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PITCH_CENTER     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_YAW_CENTER       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_AUX_CENTER       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_THROTTLE_MINIMUM = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_DEAD_ZONE        = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_SIGNAL_TIMEOUT   = 3'd6;

	localparam logic [TIME_W-1:0] CENTER_RST   = 16'd24000;
	localparam logic [TIME_W-1:0] THR_MIN_RST  = 16'd16000;
	localparam logic [DB_W-1:0]   DEADBAND_RST = 11'd2;
	localparam logic [TIME_W-1:0] TIMEOUT_RST  = 16'd20;

	typedef struct packed {
		logic              command;
		logic [CH_W-1:0]   channel;
		logic              level;
		logic [TIME_W-1:0] timer_count;
		logic [TIME_W-1:0] coarse_time;
	} req_t;

	typedef struct packed {
		logic [CH_W-1:0]           out_channel;
		logic [TIME_W-1:0]         pulse_width;
		logic                      width_updated;
		logic signed [VALUE_W-1:0] channel_value;
		logic [STATUS_W-1:0]       link_status;
	} rsp_t;

	typedef struct packed {
		logic [TIME_W-1:0] roll_center;
		logic [TIME_W-1:0] pitch_center;
		logic [TIME_W-1:0] yaw_center;
		logic [TIME_W-1:0] aux_center;
		logic [TIME_W-1:0] throttle_minimum;
		logic [DB_W-1:0]   dead_zone;
		logic [TIME_W-1:0] signal_timeout;
	} cfg_t;

	// capture stage to scaling stage
	typedef struct packed {
		logic              ch_valid;
		logic [TIME_W-1:0] width;
		logic              updated;
		logic [STATUS_W-1:0] status;
		logic              throttle_live;
	} cap_t;

endpackage

### hw/rtl/rpwc_cfg_regs.sv
// ----------------------------------------------------------------------------
// rpwc_cfg_regs
// Configuration register file: centers, throttle minimum, deadband, timeout.
// ----------------------------------------------------------------------------
module rpwc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [rpwc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rpwc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output rpwc_pkg::cfg_t                     cfg
);
	import rpwc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roll_center      <= CENTER_RST;
			cfg_q.pitch_center     <= CENTER_RST;
			cfg_q.yaw_center       <= CENTER_RST;
			cfg_q.aux_center       <= CENTER_RST;
			cfg_q.throttle_minimum <= THR_MIN_RST;
			cfg_q.dead_zone        <= DEADBAND_RST;
			cfg_q.signal_timeout   <= TIMEOUT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ROLL_CENTER:      cfg_q.roll_center      <= cfg_data;
				REG_PITCH_CENTER:     cfg_q.pitch_center     <= cfg_data;
				REG_YAW_CENTER:       cfg_q.yaw_center       <= cfg_data;
				REG_AUX_CENTER:       cfg_q.aux_center       <= cfg_data;
				REG_THROTTLE_MINIMUM: cfg_q.throttle_minimum <= cfg_data;
				REG_DEAD_ZONE:        cfg_q.dead_zone        <= cfg_data[DB_W-1:0];
				REG_SIGNAL_TIMEOUT:   cfg_q.signal_timeout   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/rpwc_capture.sv
// ----------------------------------------------------------------------------
// rpwc_capture
// Per-channel start times and widths, link stamps and link status.
// ----------------------------------------------------------------------------
module rpwc_capture #(
	parameter int NUM_CHANNELS = rpwc_pkg::NUM_CHANNELS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  rpwc_pkg::req_t item,
	input  rpwc_pkg::cfg_t cfg,
	output rpwc_pkg::cap_t cap
);
	import rpwc_pkg::*;

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [TIME_W-1:0]   start_q [NUM_CHANNELS];
	logic [TIME_W-1:0]   width_q [NUM_CHANNELS];
	logic [TIME_W-1:0]   thr_stamp_q;
	logic [TIME_W-1:0]   roll_stamp_q;
	logic [STATUS_W-1:0] status_q;

	logic                ch_valid;
	logic [IDX_W-1:0]    idx;
	logic                rising;
	logic                falling;
	logic                thr_read;
	logic [TIME_W-1:0]   start;
	logic [TIME_W-1:0]   diff;
	logic [TIME_W-1:0]   new_width;
	logic [TIME_W-1:0]   age_thr;
	logic [TIME_W-1:0]   age_roll;
	logic                thr_lost;
	logic                roll_lost;
	logic [STATUS_W-1:0] status_next;

	assign ch_valid = ({1'b0, item.channel} < (CH_W + 1)'(NUM_CHANNELS));
	assign idx      = IDX_W'(item.channel);
	assign rising   = ch_valid && (item.command == CMD_EDGE) && item.level;
	assign falling  = ch_valid && (item.command == CMD_EDGE) && !item.level;
	assign thr_read = ch_valid && (item.command == CMD_READ) && (item.channel == CH_THROTTLE);

	// wrapped case is 0xFFFF - start + now, one short of the modular difference
	assign start     = start_q[idx];
	assign diff      = item.timer_count - start;
	assign new_width = (item.timer_count > start) ? diff : diff - 16'd1;

	assign age_thr   = item.coarse_time - thr_stamp_q;
	assign age_roll  = item.coarse_time - roll_stamp_q;
	assign thr_lost  = age_thr > cfg.signal_timeout;
	assign roll_lost = age_roll > cfg.signal_timeout;

	always_comb begin
		status_next = status_q;
		if (falling && item.channel == CH_THROTTLE) begin
			status_next = STATUS_THROTTLE_SEEN;
		end else if (falling && item.channel == CH_ROLL) begin
			status_next = STATUS_ROLL_SEEN;
		end else if (thr_read && thr_lost) begin
			status_next = STATUS_NOT_FOUND;
		end else if (thr_read && roll_lost) begin
			status_next = STATUS_DISCONNECTED;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && rising) begin
			start_q[idx] <= item.timer_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				width_q[i] <= '0;
			end
			thr_stamp_q  <= '0;
			roll_stamp_q <= '0;
			status_q     <= STATUS_NOT_FOUND;
		end else if (fire) begin
			if (falling) begin
				width_q[idx] <= new_width;
				if (item.channel == CH_THROTTLE) begin
					thr_stamp_q <= item.coarse_time;
				end
				if (item.channel == CH_ROLL) begin
					roll_stamp_q <= item.coarse_time;
				end
			end
			status_q <= status_next;
		end
	end

	always_comb begin
		cap.ch_valid      = ch_valid;
		cap.updated       = falling;
		cap.status        = status_next;
		cap.throttle_live = !thr_lost && !roll_lost;
		if (!ch_valid) begin
			cap.width = '0;
		end else if (falling) begin
			cap.width = new_width;
		end else begin
			cap.width = width_q[idx];
		end
	end

endmodule

### hw/rtl/rpwc_scale.sv
// ----------------------------------------------------------------------------
// rpwc_scale
// Scaled channel value: offset, divide by 16 toward zero, saturate, deadband (throttle: link gate instead).
// ----------------------------------------------------------------------------
module rpwc_scale (
	input  rpwc_pkg::req_t                              item,
	input  rpwc_pkg::cap_t                              cap,
	input  rpwc_pkg::cfg_t                              cfg,
	output logic signed [rpwc_pkg::VALUE_W-1:0]         value
);
	import rpwc_pkg::*;

	localparam int DIFF_W = TIME_W + 1;

	logic [TIME_W-1:0]         base;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [DIFF_W-1:0]  quot;
	logic signed [VALUE_W-1:0] sat;
	logic signed [VALUE_W:0]   db;
	logic                      in_band;

	always_comb begin
		case (item.channel)
			CH_ROLL:     base = cfg.roll_center;
			CH_PITCH:    base = cfg.pitch_center;
			CH_THROTTLE: base = cfg.throttle_minimum;
			CH_YAW:      base = cfg.yaw_center;
			default:     base = cfg.aux_center;
		endcase
	end

	assign diff = $signed({1'b0, cap.width}) - $signed({1'b0, base});
	assign quot = diff[DIFF_W-1] ? ((diff + DIFF_W'(15)) >>> 4) : (diff >>> 4);

	always_comb begin
		if (quot > DIFF_W'(2047)) begin
			sat = 12'sd2047;
		end else if (quot < -DIFF_W'(2048)) begin
			sat = -12'sd2048;
		end else begin
			sat = quot[VALUE_W-1:0];
		end
	end

	assign db      = $signed({2'b00, cfg.dead_zone});
	assign in_band = (VALUE_W'(sat) < db) && (VALUE_W'(sat) > -db);

	always_comb begin
		if (!cap.ch_valid || item.command == CMD_EDGE) begin
			value = '0;
		end else if (item.channel == CH_THROTTLE) begin
			value = cap.throttle_live ? sat : '0;
		end else if (in_band) begin
			value = '0;
		end else begin
			value = sat;
		end
	end

endmodule

### hw/rtl/rc_pulse_width_capture.sv
// ----------------------------------------------------------------------------
// rc_pulse_width_capture
// Radio-control pulse-width capture with throttle/roll link supervision.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: an edge event (command 0) marks a pulse start on a rising
//  level or stores the width on a falling level; a read (command 1) asks for
//  the width and scaled value of one channel.
//  rsp channel: exactly one result per request, in request order.
//  cfg port: single-cycle register writes, done while the block is idle.
// Pipeline: a request passes the input register, then the result register,
//  before it is visible on rsp; a stall can hold it in either register.
// Throughput: one request per cycle while rsp is taken; the per-channel state
//  is updated in the same cycle the result is formed, so the next request sees it at once.
// Reset: all widths, stamps and the link status clear; pulse start times
//  hold garbage until their first rising edge.
// Stall: a held result keeps rsp_valid high; one more request waits in the
//  input register, after which req_ready drops until rsp is taken.
// ----------------------------------------------------------------------------
module rc_pulse_width_capture #(
	parameter int NUM_CHANNELS = rpwc_pkg::NUM_CHANNELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  rpwc_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output rpwc_pkg::rsp_t                   rsp,
	input  logic                             cfg_write,
	input  logic [rpwc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rpwc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rpwc_pkg::*;

	cfg_t                      cfg;
	req_t                      req_s1;
	logic                      valid_s1;
	rsp_t                      rsp_s2;
	logic                      valid_s2;
	logic                      out_free;
	logic                      fire_s1;
	cap_t                      cap;
	logic signed [VALUE_W-1:0] value;

	assign out_free  = !valid_s2 || rsp_ready;
	assign fire_s1   = valid_s1 && out_free;
	assign req_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (fire_s1) begin
			rsp_s2.out_channel   <= req_s1.channel;
			rsp_s2.pulse_width   <= cap.width;
			rsp_s2.width_updated <= cap.updated;
			rsp_s2.channel_value <= value;
			rsp_s2.link_status   <= cap.status;
		end
	end

	rpwc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rpwc_capture #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_capture (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.item   (req_s1),
		.cfg    (cfg),
		.cap    (cap)
	);

	rpwc_scale u_scale (
		.item  (req_s1),
		.cap   (cap),
		.cfg   (cfg),
		.value (value)
	);

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	// a completed measurement never carries a scaled value
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.width_updated |-> rsp.channel_value == '0)
		else $error("edge transfer carries nonzero channel value");

	// unknown channels leave width, update flag and channel value at zero
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ({1'b0, rsp.out_channel} >= (CH_W + 1)'(NUM_CHANNELS))
		|-> rsp.pulse_width == '0 && !rsp.width_updated && rsp.channel_value == '0)
		else $error("invalid channel produced data");

	// an item leaving the input register must land in the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> valid_s2)
		else $error("transfer lost between stages");

	// an empty input register never back-pressures
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req_ready)
		else $error("stall with empty input register");

endmodule
